// ===== design/lmlt_pkg.sv =====
`default_nettype none

package lmlt_pkg;

  // phase counters are 11-bit two's complement
  localparam int CNT_W  = 11;
  localparam int LINE_W = 8;
  localparam int CYC_W  = 7;

  typedef logic signed [CNT_W-1:0] cnt_t;
  typedef logic signed [CNT_W:0]   wide_t;
  typedef logic [LINE_W-1:0]       line_t;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [CYC_W-1:0] cycles;
    logic             lcd_enable;
    line_t            line_compare;
    logic             hblank_irq_en;
    logic             vblank_stat_en;
    logic             oam_irq_en;
    logic             match_irq_en;
  } item_t;

  typedef struct packed {
    mode_t mode;
    line_t line;
    logic  coincide;
    logic  vblank_irq;
    logic  stat_irq;
    logic  line_done;
    line_t done_line;
  } res_t;

  // saturate a one-bit-wider sum back into counter range
  function automatic cnt_t sat(input wide_t v);
    cnt_t r;
    if (v[CNT_W] && !v[CNT_W-1]) begin
      r = {1'b1, {(CNT_W-1){1'b0}}};
    end else if (!v[CNT_W] && v[CNT_W-1]) begin
      r = {1'b0, {(CNT_W-1){1'b1}}};
    end else begin
      r = v[CNT_W-1:0];
    end
    return r;
  endfunction

  function automatic wide_t wext(input cnt_t c);
    return {c[CNT_W-1], c};
  endfunction

  function automatic logic expired(input cnt_t c);
    return c[CNT_W-1] || (c == '0);
  endfunction

endpackage

`default_nettype wire

// ===== design/lcd_mode_line_timing.sv =====
// An accepted input beat passes the input register, then the result register
//   behind the update logic, before its result beat appears.
// Throughput: one beat per cycle unless stalled; update is a few adds and compares.
// Reset (rst_n low, synchronous): pipeline empties, mode and line go to 0,
//   phase counters reload their full lengths.
`default_nettype none

module lcd_mode_line_timing #(
  parameter int HBLANK_CYCLES = 204,
  parameter int OAM_CYCLES    = 80,
  parameter int XFER_CYCLES   = 172,
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int TOTAL_LINES   = 154
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [6:0] in_cycles,
  input  wire logic       in_lcd_enable,
  input  wire logic [7:0] in_line_compare,
  input  wire logic       in_hblank_irq_en,
  input  wire logic       in_vblank_stat_en,
  input  wire logic       in_oam_irq_en,
  input  wire logic       in_match_irq_en,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_mode,
  output logic [7:0]      out_line,
  output logic            out_coincide,
  output logic            out_vblank_irq,
  output logic            out_stat_irq,
  output logic            out_line_done,
  output logic [7:0]      out_done_line
);

  logic            in_vld_r;
  lmlt_pkg::item_t item_r;
  logic            out_vld_r;
  lmlt_pkg::res_t  res_r;
  lmlt_pkg::res_t  res_nxt;
  logic            blocked;
  logic            step;

  assign blocked  = out_vld_r && out_stall;
  assign step     = in_vld_r && !blocked;
  assign in_stall = in_vld_r && blocked;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.cycles         <= in_cycles;
      item_r.lcd_enable     <= in_lcd_enable;
      item_r.line_compare   <= in_line_compare;
      item_r.hblank_irq_en  <= in_hblank_irq_en;
      item_r.vblank_stat_en <= in_vblank_stat_en;
      item_r.oam_irq_en     <= in_oam_irq_en;
      item_r.match_irq_en   <= in_match_irq_en;
    end
  end

  lmlt_core #(
    .HBLANK_CYCLES(HBLANK_CYCLES),
    .OAM_CYCLES   (OAM_CYCLES),
    .XFER_CYCLES  (XFER_CYCLES),
    .LINE_CYCLES  (LINE_CYCLES),
    .VISIBLE_LINES(VISIBLE_LINES),
    .TOTAL_LINES  (TOTAL_LINES)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .step (step),
    .item (item_r),
    .res  (res_nxt)
  );

  // result beat holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!blocked) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_mode       = res_r.mode;
  assign out_line       = res_r.line;
  assign out_coincide   = res_r.coincide;
  assign out_vblank_irq = res_r.vblank_irq;
  assign out_stat_irq   = res_r.stat_irq;
  assign out_line_done  = res_r.line_done;
  assign out_done_line  = res_r.done_line;

endmodule

`default_nettype wire

// ===== design/lmlt_core.sv =====
`default_nettype none

module lmlt_core #(
  parameter int HBLANK_CYCLES = 204,
  parameter int OAM_CYCLES    = 80,
  parameter int XFER_CYCLES   = 172,
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int TOTAL_LINES   = 154
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire lmlt_pkg::item_t item,
  output lmlt_pkg::res_t      res
);

  localparam lmlt_pkg::cnt_t HB_INIT   = lmlt_pkg::CNT_W'(HBLANK_CYCLES);
  localparam lmlt_pkg::cnt_t OAM_INIT  = lmlt_pkg::CNT_W'(OAM_CYCLES);
  localparam lmlt_pkg::cnt_t XFER_INIT = lmlt_pkg::CNT_W'(XFER_CYCLES);
  localparam lmlt_pkg::cnt_t LINE_INIT = lmlt_pkg::CNT_W'(LINE_CYCLES);
  localparam lmlt_pkg::line_t VIS_LN   = lmlt_pkg::LINE_W'(VISIBLE_LINES);
  localparam lmlt_pkg::line_t TOT_LN   = lmlt_pkg::LINE_W'(TOTAL_LINES);

  lmlt_pkg::mode_t mode_r, mode_nxt;
  lmlt_pkg::line_t line_r, line_nxt;
  logic            match_r, match_nxt;
  lmlt_pkg::cnt_t  hb_r, hb_nxt;
  lmlt_pkg::cnt_t  oam_r, oam_nxt;
  lmlt_pkg::cnt_t  xfer_r, xfer_nxt;
  lmlt_pkg::cnt_t  ll_r, ll_nxt;

  lmlt_pkg::wide_t cyc_w;
  logic            vbl, stat, done;
  lmlt_pkg::line_t done_ln;

  always_comb begin
    cyc_w     = {{(lmlt_pkg::CNT_W + 1 - lmlt_pkg::CYC_W){1'b0}}, item.cycles};
    mode_nxt  = mode_r;
    line_nxt  = line_r;
    match_nxt = match_r;
    hb_nxt    = hb_r;
    oam_nxt   = oam_r;
    xfer_nxt  = xfer_r;
    ll_nxt    = ll_r;
    vbl       = 1'b0;
    stat      = 1'b0;
    done      = 1'b0;
    done_ln   = '0;

    if (!item.lcd_enable) begin
      mode_nxt  = lmlt_pkg::MODE_HBLANK;
      line_nxt  = '0;
      match_nxt = 1'b0;
      hb_nxt    = HB_INIT;
      oam_nxt   = OAM_INIT;
      xfer_nxt  = XFER_INIT;
      ll_nxt    = LINE_INIT;
    end else begin
      case (mode_r)
        lmlt_pkg::MODE_OAM: begin
          oam_nxt = lmlt_pkg::sat(lmlt_pkg::wext(oam_r) - cyc_w);
          if (lmlt_pkg::expired(oam_nxt)) begin
            xfer_nxt = lmlt_pkg::sat(lmlt_pkg::wext(xfer_r) + lmlt_pkg::wext(oam_nxt));
            oam_nxt  = OAM_INIT;
            mode_nxt = lmlt_pkg::MODE_XFER;
          end
        end
        lmlt_pkg::MODE_XFER: begin
          xfer_nxt = lmlt_pkg::sat(lmlt_pkg::wext(xfer_r) - cyc_w);
          if (lmlt_pkg::expired(xfer_nxt)) begin
            hb_nxt   = lmlt_pkg::sat(lmlt_pkg::wext(hb_r) + lmlt_pkg::wext(xfer_nxt));
            xfer_nxt = XFER_INIT;
            mode_nxt = lmlt_pkg::MODE_HBLANK;
            if (line_r < VIS_LN) begin
              done    = 1'b1;
              done_ln = line_r;
            end
            stat = item.hblank_irq_en;
          end
        end
        lmlt_pkg::MODE_HBLANK: begin
          hb_nxt = lmlt_pkg::sat(lmlt_pkg::wext(hb_r) - cyc_w);
          if (lmlt_pkg::expired(hb_nxt) && (line_r < VIS_LN)) begin
            oam_nxt  = lmlt_pkg::sat(lmlt_pkg::wext(oam_r) + lmlt_pkg::wext(hb_nxt));
            hb_nxt   = HB_INIT;
            mode_nxt = lmlt_pkg::MODE_OAM;
            stat     = item.oam_irq_en;
          end
        end
        default: begin
          // vertical blank ends only once the line counter has wrapped
          if (line_r == '0) begin
            mode_nxt = lmlt_pkg::MODE_OAM;
            stat     = item.oam_irq_en;
          end
        end
      endcase

      ll_nxt = lmlt_pkg::sat(lmlt_pkg::wext(ll_r) - cyc_w);
      if (lmlt_pkg::expired(ll_nxt)) begin
        ll_nxt = lmlt_pkg::sat(lmlt_pkg::wext(ll_nxt) + lmlt_pkg::wext(LINE_INIT));
        if (item.line_compare == line_r) begin
          match_nxt = 1'b1;
          stat      = stat | item.match_irq_en;
        end else begin
          match_nxt = 1'b0;
        end
        line_nxt = line_r + lmlt_pkg::LINE_W'(1);
        if (line_nxt == TOT_LN) begin
          line_nxt = '0;
        end
      end

      if ((line_nxt == VIS_LN) && (mode_r != lmlt_pkg::MODE_VBLANK)) begin
        hb_nxt   = HB_INIT;
        mode_nxt = lmlt_pkg::MODE_VBLANK;
        vbl      = 1'b1;
        stat     = stat | item.vblank_stat_en;
      end
    end

    res.mode       = mode_nxt;
    res.line       = line_nxt;
    res.coincide   = match_nxt;
    res.vblank_irq = vbl;
    res.stat_irq   = stat;
    res.line_done  = done;
    res.done_line  = done_ln;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= lmlt_pkg::MODE_HBLANK;
      line_r  <= '0;
      match_r <= 1'b0;
      hb_r    <= HB_INIT;
      oam_r   <= OAM_INIT;
      xfer_r  <= XFER_INIT;
      ll_r    <= LINE_INIT;
    end else if (step) begin
      mode_r  <= mode_nxt;
      line_r  <= line_nxt;
      match_r <= match_nxt;
      hb_r    <= hb_nxt;
      oam_r   <= oam_nxt;
      xfer_r  <= xfer_nxt;
      ll_r    <= ll_nxt;
    end
  end

endmodule

`default_nettype wire
